/* rtl/bcrm_pkg.sv */
// Package for the bitmap column-run rectangle merge block.
// Holds shared constants, opcodes, register indexes and the sequencer state type.
// No dependencies.
package bcrm_pkg;

  // Default grid dimensions handed to the top level parameters.
  localparam int unsigned MaxColumnsDef = 64;
  localparam int unsigned MaxRowsDef    = 64;

  // Fixed field widths of the item and result ports.
  localparam int unsigned ColIdxW = 6;
  localparam int unsigned CellsW  = 64;
  localparam int unsigned RowIdxW = 6;
  localparam int unsigned CountW  = 7;

  // Item opcodes.
  localparam logic OpLoad      = 1'b0;
  localparam logic OpDecompose = 1'b1;

  // Configuration register indexes and their values after reset.
  localparam logic CfgColumns = 1'b0;
  localparam logic CfgRows    = 1'b1;
  localparam logic [CountW-1:0] ColumnsReset = 7'd21;
  localparam logic [CountW-1:0] RowsReset    = 7'd21;

  // Decompose sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_RUN,
    ST_EXT,
    ST_EMIT
  } state_e;

endpackage

/* rtl/bcrm_grid.sv */
// Column word store of the bitmap grid: one write port, one registered read port.
// Per-entry valid bits make never-written columns read as all zero after reset.
// Depends on nothing but its parameters.
module bcrm_grid #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rd_data_q;
  logic             rd_vld_q;

  // Storage array, no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem[raddr_i];
    end
  end

  // Valid bits: an entry becomes valid on its first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  // An entry never written reads as empty.
  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* rtl/bitmap_column_run_rectangle_merge_top.sv */
// Top level of the bitmap column-run rectangle merge block.
// Depends on bcrm_pkg and bcrm_grid.
//
// A load item writes one column word at the edge that takes it, and busy stays low. A
// decompose of a column out of use, or with no rows in use, is dropped the same way. Any
// other decompose item holds busy high from the next cycle while one sequencer walks the
// column with a single shared compare against the registered read port of the grid store.
// It reads the column in ST_READ, then steps row by row in ST_SCAN and ST_RUN from the top
// down to the bottom of its last run. Each run is closed in ST_RUN, then compares the
// following columns in use against it in ST_EXT (every column it absorbs, plus the first one
// that does not cover it) and presents the rectangle on the result ports with rect_valid_o
// in ST_EMIT. An empty column passes only through ST_READ and ST_SCAN. Results cannot be
// held off: each one is on the ports for exactly one cycle. Configuration writes are
// always taken (cfg_ready_o is high); the user must keep them to the idle periods, as the
// block itself does not enforce this.
module bitmap_column_run_rectangle_merge_top #(
  parameter int unsigned MAX_COLUMNS = bcrm_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = bcrm_pkg::MaxRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [bcrm_pkg::ColIdxW-1:0]   column_index_i,
  input  logic [bcrm_pkg::CellsW-1:0]    column_cells_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [bcrm_pkg::CountW-1:0]    cfg_data_i,
  output logic                           rect_valid_o,
  output logic [bcrm_pkg::ColIdxW-1:0]   rect_column_o,
  output logic [bcrm_pkg::RowIdxW-1:0]   rect_first_row_o,
  output logic [bcrm_pkg::RowIdxW-1:0]   rect_last_row_o,
  output logic [bcrm_pkg::CountW-1:0]    rect_width_o,
  output logic                           last_of_column_o
);
  import bcrm_pkg::*;

  localparam int unsigned AddrW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColLimit = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;

  state_e state_q, state_d;

  logic [CountW-1:0]   cols_q, rows_q;
  logic [ColIdxW-1:0]  col_q, col_d;
  logic [MAX_ROWS-1:0] work_q, work_d;
  logic [MAX_ROWS-1:0] mask_q, mask_d;
  logic [RW:0]         row_q, row_d;
  logic [RW-1:0]       first_q, first_d;
  logic [RW-1:0]       last_q, last_d;
  logic [CountW-1:0]   next_q, next_d;
  logic [CountW-1:0]   add_q, add_d;

  logic [CountW-1:0]   ncols, nrows;
  logic [MAX_ROWS-1:0] row_mask;
  logic                row_bit;
  logic [CountW-1:0]   col_plus, next_plus;
  logic                hit;

  logic                g_we, g_re;
  logic [AddrW-1:0]    g_waddr, g_raddr;
  logic [MAX_ROWS-1:0] g_wdata, g_rdata;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColumnsReset;
      rows_q <= RowsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgColumns: cols_q <= cfg_data_i;
        CfgRows:    rows_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Effective column and row counts, clipped to the grid size.
  assign ncols = (cols_q > CountW'(ColLimit)) ? CountW'(ColLimit) : cols_q;
  assign nrows = (rows_q > CountW'(MAX_ROWS)) ? CountW'(MAX_ROWS) : rows_q;

  // Rows in use as a thermometer mask.
  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      row_mask[i] = (CountW'(i) < nrows);
    end
  end

  // Current row bit of the working copy; past the grid it reads clear.
  assign row_bit   = (row_q < (RW + 1)'(MAX_ROWS)) ? work_q[row_q[RW-1:0]] : 1'b0;
  assign col_plus  = {1'b0, col_q} + CountW'(1);
  assign next_plus = next_q + CountW'(1);
  assign hit       = ((g_rdata & mask_q) == mask_q);

  // Grid store.
  bcrm_grid #(
    .Depth (MAX_COLUMNS),
    .Width (MAX_ROWS),
    .AddrW (AddrW)
  ) u_grid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // Sequencer state and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      next_q  <= '0;
      add_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      next_q  <= next_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    work_q  <= work_d;
    mask_q  <= mask_d;
    first_q <= first_d;
    last_q  <= last_d;
  end

  // Next state, grid accesses and result strobe.
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    work_d  = work_q;
    mask_d  = mask_q;
    row_d   = row_q;
    first_d = first_q;
    last_d  = last_q;
    next_d  = next_q;
    add_d   = add_q;
    g_we    = 1'b0;
    g_waddr = AddrW'(next_q);
    g_wdata = g_rdata & ~mask_q;
    g_re    = 1'b0;
    g_raddr = AddrW'(next_plus);

    unique case (state_q)
      ST_IDLE: begin
        g_waddr = AddrW'(column_index_i);
        g_wdata = column_cells_i[MAX_ROWS-1:0];
        g_raddr = AddrW'(column_index_i);
        col_d   = column_index_i;
        if (start) begin
          if (opcode_i == OpLoad) begin
            g_we = ({1'b0, column_index_i} < CountW'(ColLimit));
          end else if (({1'b0, column_index_i} < ncols) && (nrows != '0)) begin
            g_re    = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        work_d  = g_rdata & row_mask;
        row_d   = '0;
        state_d = ST_SCAN;
      end
      // Skip clear rows until a run starts or nothing is left.
      ST_SCAN: begin
        if (work_q == '0) begin
          state_d = ST_IDLE;
        end else if (row_bit) begin
          work_d[row_q[RW-1:0]] = 1'b0;
          mask_d  = '0;
          mask_d[row_q[RW-1:0]] = 1'b1;
          first_d = row_q[RW-1:0];
          last_d  = row_q[RW-1:0];
          add_d   = '0;
          row_d   = row_q + (RW + 1)'(1);
          state_d = ST_RUN;
        end else begin
          row_d = row_q + (RW + 1)'(1);
        end
      end
      // Grow the run downward; at its end start on the next column, if one is in use.
      ST_RUN: begin
        if (row_bit) begin
          work_d[row_q[RW-1:0]] = 1'b0;
          mask_d[row_q[RW-1:0]] = 1'b1;
          last_d = row_q[RW-1:0];
          row_d  = row_q + (RW + 1)'(1);
        end else if (col_plus < ncols) begin
          g_re    = 1'b1;
          g_raddr = AddrW'(col_plus);
          next_d  = col_plus;
          state_d = ST_EXT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      // Absorb one following column per cycle while it covers the run.
      ST_EXT: begin
        if (hit) begin
          g_we  = 1'b1;
          add_d = add_q + CountW'(1);
          if (next_plus < ncols) begin
            g_re   = 1'b1;
            next_d = next_plus;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_d = (work_q == '0) ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result ports.
  assign busy             = (state_q != ST_IDLE);
  assign rect_valid_o     = (state_q == ST_EMIT);
  assign rect_column_o    = col_q;
  assign rect_first_row_o = RowIdxW'(first_q);
  assign rect_last_row_o  = RowIdxW'(last_q);
  assign rect_width_o     = add_q + CountW'(1);
  assign last_of_column_o = (work_q == '0);

  // A rectangle never reaches past the columns in use.
  a_rect_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> ((CountW'(rect_column_o) + rect_width_o) <= ncols))
    else $error("rectangle extends past the columns in use");

  // The run's rows are ordered.
  a_rows_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> (rect_first_row_o <= rect_last_row_o))
    else $error("rectangle first row below last row");

  // The final rectangle of a column ends the item.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rect_valid_o && last_of_column_o) |=> !busy)
    else $error("block still busy after the final rectangle");

  // A load item finishes in the cycle it is taken.
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OpLoad)) |=> !busy)
    else $error("load item left the block busy");

  // Grid writes during a decompose happen only for covering columns.
  a_write_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_we && busy) |-> ((state_q == ST_EXT) && hit))
    else $error("grid written outside column absorption");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_column_run_rectangle_merge_top: loads column words,
// requests decompositions and checks every rectangle against a built-in greedy splitter.
// Depends on bcrm_pkg and the RTL of the block.
module tb_top;
  import bcrm_pkg::*;

  // Idle time given after the last expected rectangle so that a result-free decompose
  // can finish.
  localparam int unsigned DrainCycles = 2200;
  // Watchdog limit for the whole run.
  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned ItemTarget  = 380;

  typedef struct packed {
    logic [ColIdxW-1:0] column;
    logic [RowIdxW-1:0] first_row;
    logic [RowIdxW-1:0] last_row;
    logic [CountW-1:0]  width;
    logic               last_flag;
  } rect_t;

  // Shadow grid, register copies and the queue of rectangles still to come.
  class rect_scoreboard;
    logic [CellsW-1:0] cells_shadow [MaxColumnsDef];
    logic [CountW-1:0] col_limit;
    logic [CountW-1:0] row_limit;
    rect_t             pending_rects [$];
    int unsigned       mismatches;
    int unsigned       checked_rects;

    function new();
      foreach (cells_shadow[i]) cells_shadow[i] = '0;
      col_limit     = ColumnsReset;
      row_limit     = RowsReset;
      mismatches    = 0;
      checked_rects = 0;
    endfunction

    function void write_reg(logic idx, logic [CountW-1:0] val);
      if (idx == CfgColumns) col_limit = val;
      else row_limit = val;
    endfunction

    function int unsigned used_cols();
      return (col_limit > MaxColumnsDef) ? MaxColumnsDef : col_limit;
    endfunction

    function int unsigned used_rows();
      return (row_limit > MaxRowsDef) ? MaxRowsDef : row_limit;
    endfunction

    // Apply one accepted item and queue the rectangles a decompose produces.
    function void note_item(logic op, logic [ColIdxW-1:0] col, logic [CellsW-1:0] cells);
      int unsigned       ncols, nrows, row, first, nxt, runs;
      logic [CellsW-1:0] word, span, ones;
      rect_t             cur, prev;
      bit                have_prev;
      if (op == OpLoad) begin
        cells_shadow[col] = cells;
        return;
      end
      ncols = used_cols();
      nrows = used_rows();
      if (col >= ncols || nrows == 0) return;
      word      = cells_shadow[col];
      ones      = '1;
      have_prev = 1'b0;
      runs      = 0;
      row       = 0;
      while (row < nrows && runs < 32) begin
        if (!word[row]) begin
          row++;
          continue;
        end
        first = row;
        // A run that reaches the last row in use is closed there.
        while (row + 1 < nrows && word[row + 1]) row++;
        cur           = '0;
        cur.column    = col;
        cur.first_row = RowIdxW'(first);
        cur.last_row  = RowIdxW'(row);
        cur.width     = CountW'(1);
        span = (ones >> (63 - (row - first))) << first;
        // Absorb following columns while they cover the whole run.
        for (nxt = col + 1; nxt < ncols; nxt++) begin
          if ((cells_shadow[nxt] & span) != span) break;
          cells_shadow[nxt] &= ~span;
          cur.width++;
        end
        row++;
        if (have_prev) pending_rects.push_back(prev);
        prev      = cur;
        have_prev = 1'b1;
        runs++;
      end
      if (have_prev) begin
        prev.last_flag = 1'b1;
        pending_rects.push_back(prev);
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one emitted rectangle with the oldest one expected.
    task check_rect(rect_t got);
      rect_t want;
      if (pending_rects.size() == 0) begin
        report_mismatch($sformatf("unexpected rectangle col %0d rows %0d..%0d width %0d",
                                  got.column, got.first_row, got.last_row, got.width));
        return;
      end
      want = pending_rects.pop_front();
      checked_rects++;
      if (got.column != want.column)
        report_mismatch($sformatf("rect %0d column %0d, expected %0d",
                                  checked_rects, got.column, want.column));
      if (got.first_row != want.first_row)
        report_mismatch($sformatf("rect %0d first row %0d, expected %0d",
                                  checked_rects, got.first_row, want.first_row));
      if (got.last_row != want.last_row)
        report_mismatch($sformatf("rect %0d last row %0d, expected %0d",
                                  checked_rects, got.last_row, want.last_row));
      if (got.width != want.width)
        report_mismatch($sformatf("rect %0d width %0d, expected %0d",
                                  checked_rects, got.width, want.width));
      if (got.last_flag != want.last_flag)
        report_mismatch($sformatf("rect %0d last flag %0d, expected %0d",
                                  checked_rects, got.last_flag, want.last_flag));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic                opcode_i       = OpLoad;
  logic [ColIdxW-1:0]  column_index_i = '0;
  logic [CellsW-1:0]   column_cells_i = '0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i    = CfgColumns;
  logic [CountW-1:0]   cfg_data_i     = '0;
  logic                rect_valid_o;
  logic [ColIdxW-1:0]  rect_column_o;
  logic [RowIdxW-1:0]  rect_first_row_o;
  logic [RowIdxW-1:0]  rect_last_row_o;
  logic [CountW-1:0]   rect_width_o;
  logic                last_of_column_o;

  rect_scoreboard rect_sb = new();
  int unsigned    cycle_cnt     = 0;
  int unsigned    items_sent    = 0;
  int unsigned    loads_sent    = 0;
  int unsigned    decomps_sent  = 0;
  int unsigned    settings_used = 1;
  bit             quiet_stretch = 1'b0;

  bitmap_column_run_rectangle_merge_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .column_index_i   (column_index_i),
    .column_cells_i   (column_cells_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .rect_valid_o     (rect_valid_o),
    .rect_column_o    (rect_column_o),
    .rect_first_row_o (rect_first_row_o),
    .rect_last_row_o  (rect_last_row_o),
    .rect_width_o     (rect_width_o),
    .last_of_column_o (last_of_column_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Run exceeded %0d cycles.", CycleLimit);
    $display("TEST FAILED");
    $finish;
  end

  // Monitor: results are checked before a new item is noted on the same edge.
  always @(posedge clk_i) begin : monitor
    rect_t seen;
    if (rst_ni) begin
      if (rect_valid_o) begin
        seen = '{rect_column_o, rect_first_row_o, rect_last_row_o, rect_width_o,
                 last_of_column_o};
        rect_sb.check_rect(seen);
      end
      if (start && !busy) rect_sb.note_item(opcode_i, column_index_i, column_cells_i);
    end
  end

  function automatic logic [CellsW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Word made of vertical runs of random length separated by short gaps.
  function automatic logic [CellsW-1:0] run_word();
    logic [CellsW-1:0] w;
    int unsigned       r, len, i;
    w = '0;
    r = $urandom_range(0, 5);
    while (r < CellsW) begin
      len = $urandom_range(1, 10);
      for (i = 0; i < len && r < CellsW; i++) begin
        w[r] = 1'b1;
        r++;
      end
      r += $urandom_range(1, 5);
    end
    return w;
  endfunction

  // Mostly legal register values, with out-of-range and tiny ones mixed in.
  function automatic logic [CountW-1:0] pick_limit();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return CountW'($urandom_range(65, 127));
    if (roll == 1) return CountW'($urandom_range(1, 4));
    return CountW'($urandom_range(1, 64));
  endfunction

  // Each cycle stays idle with a chance of 37 in 100, except during the quiet stretch.
  task automatic maybe_idle();
    while (!quiet_stretch && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Present one item and hold it until the block takes it.
  task automatic send_item(logic op, int unsigned col, logic [CellsW-1:0] cells);
    start          <= 1'b1;
    opcode_i       <= op;
    column_index_i <= ColIdxW'(col);
    column_cells_i <= cells;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (op == OpLoad) loads_sent++;
    else decomps_sent++;
    quiet_stretch = (items_sent >= 200 && items_sent < 280);
    maybe_idle();
  endtask

  // Wait for every expected rectangle, then let any result-free decompose finish.
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk_i);
    while (rect_sb.pending_rects.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CountW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    rect_sb.write_reg(idx, val);
  endtask

  task automatic set_phase(logic [CountW-1:0] cols, logic [CountW-1:0] rows);
    drain_block();
    write_cfg(CfgColumns, cols);
    write_cfg(CfgRows, rows);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Load a column and a few related neighbors, then decompose it, and sometimes the next column.
  task automatic run_scene();
    int unsigned       span_cols, nrows, c, k, j;
    logic [CellsW-1:0] base, w;
    span_cols = rect_sb.used_cols();
    nrows     = rect_sb.used_rows();
    if (span_cols == 0 || $urandom_range(0, 9) == 0) c = $urandom_range(0, 63);
    else c = $urandom_range(0, span_cols - 1);
    base = run_word();
    if (nrows != 0 && $urandom_range(0, 2) == 0) base[nrows - 1] = 1'b1;
    send_item(OpLoad, c, base);
    k = $urandom_range(0, 6);
    for (j = 1; j <= k && c + j < MaxColumnsDef; j++) begin
      case ($urandom_range(0, 3))
        0: w = base;
        1: w = base | (rand_word() & rand_word());
        2: w = base & ~(rand_word() & rand_word() & rand_word());
        default: w = '1;
      endcase
      send_item(OpLoad, c + j, w);
    end
    send_item(OpDecompose, c, rand_word());
    if ($urandom_range(0, 2) == 0) send_item(OpDecompose, (c + 1) % MaxColumnsDef, rand_word());
  endtask

  task automatic noise_item();
    if ($urandom_range(0, 1) == 0) send_item(OpLoad, $urandom_range(0, 63), rand_word());
    else send_item(OpDecompose, $urandom_range(0, 63), rand_word());
  endtask

  // Main stimulus.
  initial begin
    int unsigned phase, phase_end;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, 21 by 21: merge across columns, last-row run, unused column.
    send_item(OpLoad, 0, '1);
    send_item(OpLoad, 1, '1);
    send_item(OpLoad, 2, 64'h0000_0000_001F_FFFF);
    send_item(OpDecompose, 0, '0);
    send_item(OpDecompose, 1, '0);
    send_item(OpLoad, 5, 64'h0000_0000_0010_0000);
    send_item(OpDecompose, 5, '1);
    send_item(OpDecompose, 21, '0);

    // Full grid: rightmost columns, row 63, and the maximum of 32 runs.
    set_phase(64, 64);
    send_item(OpLoad, 62, '1);
    send_item(OpLoad, 63, '1);
    send_item(OpDecompose, 62, '0);
    send_item(OpDecompose, 63, '0);
    send_item(OpLoad, 63, 64'h8000_0000_0000_0000);
    send_item(OpDecompose, 63, '0);
    send_item(OpLoad, 10, 64'h5555_5555_5555_5555);
    send_item(OpLoad, 11, '1);
    send_item(OpDecompose, 10, '0);
    send_item(OpDecompose, 11, '0);
    send_item(OpDecompose, 0, '0);

    // Smallest grid, then zero rows, zero columns and clamped values.
    set_phase(1, 1);
    send_item(OpDecompose, 0, '0);
    send_item(OpDecompose, 1, '0);
    set_phase(64, 0);
    send_item(OpDecompose, 0, '0);
    set_phase(0, 64);
    send_item(OpDecompose, 0, '0);
    set_phase(127, 127);
    send_item(OpLoad, 0, 64'h8000_0000_0000_0001);
    send_item(OpDecompose, 0, '0);

    // Random scenes under a series of register settings.
    for (phase = 0; items_sent < ItemTarget; phase++) begin
      if (phase == 0) set_phase(64, 64);
      else set_phase(pick_limit(), pick_limit());
      phase_end = items_sent + 60;
      while (items_sent < phase_end && items_sent < ItemTarget) begin
        if ($urandom_range(0, 9) < 7) run_scene();
        else noise_item();
      end
    end

    drain_block();
    $display("Covered %0d items (%0d loads, %0d decomposes) under %0d register settings.",
             items_sent, loads_sent, decomps_sent, settings_used);
    $display("Checked %0d rectangles with %0d mismatches.",
             rect_sb.checked_rects, rect_sb.mismatches);
    if (rect_sb.mismatches == 0 && rect_sb.pending_rects.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
